### rtl/timer_bank_unit_assert.svh
// assertion macros used by the checker file
`ifndef TIMER_BANK_UNIT_ASSERT_SVH
`define TIMER_BANK_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define TBU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer bank check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define TBU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank check failed");

`endif

### rtl/tbu_pkg.sv
package tbu_pkg;

  // bank size and derived widths
  localparam int TIMER_SLOTS = 8;
  localparam int IDX_W       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  // fixed field widths
  localparam int MODE_W  = 3;
  localparam int SLOT_W  = 3;
  localparam int TIME_W  = 32;
  localparam int DELTA_W = 16;
  localparam int KIND_W  = 2;
  localparam int CMP_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // input operations
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_ONCE = 3'd0,
    MODE_ADD_REP  = 3'd1,
    MODE_CANCEL   = 3'd2,
    MODE_PAUSE    = 3'd3,
    MODE_RESUME   = 3'd4,
    MODE_TICK     = 3'd5,
    MODE_CLEAR    = 3'd6,
    MODE_QUERY    = 3'd7
  } mode_t;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_FIRE  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  // item travelling down the cell chain, with what the cells add to it
  typedef struct packed {
    logic                   vld;
    mode_t                  mode;
    logic [SLOT_W-1:0]      slot;
    logic [TIME_W-1:0]      ival;
    logic [DELTA_W-1:0]     delta;
    logic                   placed;
    logic [IDX_W-1:0]       place_idx;
    logic [TIMER_SLOTS-1:0] fires;
    logic [TIME_W-1:0]      rem;
  } link_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [IDX_W-1:0] lowest_idx(input logic [TIMER_SLOTS-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### rtl/tbu_cell.sv
module tbu_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [tbu_pkg::IDX_W-1:0] idx,
  input  logic                  adv,
  input  tbu_pkg::link_t        lnk_in,
  output tbu_pkg::link_t        lnk_out
);
  import tbu_pkg::*;

  // slot state
  logic              in_use;
  logic              paused;
  logic              repeats;
  logic [TIME_W-1:0] interval;
  logic [TIME_W-1:0] elapsed;

  logic              in_use_next;
  logic              paused_next;
  logic              repeats_next;
  logic [TIME_W-1:0] interval_next;
  logic [TIME_W-1:0] elapsed_next;
  link_t             lnk_next;

  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] sat;
  logic              hit;
  logic              live;

  // saturating elapsed time and slot match
  always_comb begin
    sum  = {1'b0, elapsed} + (TIME_W + 1)'(lnk_in.delta);
    sat  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    hit  = (CMP_W'(lnk_in.slot) == CMP_W'(idx));
    live = in_use && !paused;
  end

  // per-operation update of this slot and of the passing item
  always_comb begin
    in_use_next   = in_use;
    paused_next   = paused;
    repeats_next  = repeats;
    interval_next = interval;
    elapsed_next  = elapsed;
    lnk_next      = lnk_in;
    if (adv && lnk_in.vld) begin
      unique case (lnk_in.mode) inside
        MODE_ADD_ONCE, MODE_ADD_REP: begin
          if (!lnk_in.placed && !in_use) begin
            in_use_next        = 1'b1;
            paused_next        = 1'b0;
            repeats_next       = (lnk_in.mode == MODE_ADD_REP);
            interval_next      = lnk_in.ival;
            elapsed_next       = '0;
            lnk_next.placed    = 1'b1;
            lnk_next.place_idx = idx;
          end
        end
        MODE_CANCEL: begin
          if (hit) begin
            in_use_next = 1'b0;
            paused_next = 1'b0;
          end
        end
        MODE_PAUSE: begin
          if (hit && in_use) begin
            paused_next = 1'b1;
          end
        end
        MODE_RESUME: begin
          if (hit && in_use) begin
            paused_next = 1'b0;
          end
        end
        MODE_TICK: begin
          if (live) begin
            elapsed_next = sat;
            if (sat >= interval) begin
              lnk_next.fires[idx] = 1'b1;
              if (repeats) begin
                elapsed_next = '0;
              end else begin
                in_use_next = 1'b0;
                paused_next = 1'b0;
              end
            end
          end
        end
        MODE_CLEAR: begin
          in_use_next = 1'b0;
          paused_next = 1'b0;
        end
        MODE_QUERY: begin
          if (hit && live && (interval > elapsed)) begin
            lnk_next.rem = interval - elapsed;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state and hop register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use      <= 1'b0;
      paused      <= 1'b0;
      lnk_out.vld <= 1'b0;
    end else begin
      in_use <= in_use_next;
      paused <= paused_next;
      if (adv) begin
        lnk_out <= lnk_next;
      end
    end
  end

  // slot payload, written before it is ever read
  always_ff @(posedge clk) begin
    repeats  <= repeats_next;
    interval <= interval_next;
    elapsed  <= elapsed_next;
  end

endmodule

### rtl/tbu_emit.sv
module tbu_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  tbu_pkg::link_t             lnk,
  output logic                       take,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [tbu_pkg::KIND_W-1:0] kind,
  output logic [tbu_pkg::SLOT_W-1:0] slot_out,
  output logic                       full_res,
  output logic [tbu_pkg::TIME_W-1:0] remaining_us,
  output logic                       last
);
  import tbu_pkg::*;

  // fires still to be sent for the current tick
  logic [TIMER_SLOTS-1:0] pend;
  logic [TIMER_SLOTS-1:0] pend_next;

  logic                   out_valid_next;
  logic [KIND_W-1:0]      kind_next;
  logic [SLOT_W-1:0]      slot_out_next;
  logic                   full_res_next;
  logic [TIME_W-1:0]      remaining_us_next;
  logic                   last_next;

  logic                   free;
  logic [TIMER_SLOTS-1:0] src;
  logic [TIMER_SLOTS-1:0] rest;
  logic [IDX_W-1:0]       low;

  // lowest pending fire and what remains after it
  always_comb begin
    free = !out_valid || !out_stall;
    take = lnk.vld && (pend == '0) && free;
    src  = take ? lnk.fires : pend;
    rest = src & (src - TIMER_SLOTS'(1));
    low  = lowest_idx(src);
  end

  // result register load
  always_comb begin
    out_valid_next    = out_valid && out_stall;
    kind_next         = kind;
    slot_out_next     = slot_out;
    full_res_next     = full_res;
    remaining_us_next = remaining_us;
    last_next         = last;
    pend_next         = pend;
    if (take) begin
      case (lnk.mode) inside
        MODE_ADD_ONCE, MODE_ADD_REP: begin
          out_valid_next    = 1'b1;
          kind_next         = KIND_ADD;
          slot_out_next     = lnk.placed ? SLOT_W'(lnk.place_idx) : '0;
          full_res_next     = !lnk.placed;
          remaining_us_next = '0;
          last_next         = 1'b1;
        end
        MODE_QUERY: begin
          out_valid_next    = 1'b1;
          kind_next         = KIND_QUERY;
          slot_out_next     = lnk.slot;
          full_res_next     = 1'b0;
          remaining_us_next = lnk.rem;
          last_next         = 1'b1;
        end
        MODE_TICK: begin
          if (src != '0) begin
            out_valid_next    = 1'b1;
            kind_next         = KIND_FIRE;
            slot_out_next     = SLOT_W'(low);
            full_res_next     = 1'b0;
            remaining_us_next = '0;
            last_next         = (rest == '0);
            pend_next         = rest;
          end
        end
        default: begin
        end
      endcase
    end else if ((pend != '0) && free) begin
      out_valid_next    = 1'b1;
      kind_next         = KIND_FIRE;
      slot_out_next     = SLOT_W'(low);
      full_res_next     = 1'b0;
      remaining_us_next = '0;
      last_next         = (rest == '0);
      pend_next         = rest;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= '0;
    end else begin
      out_valid <= out_valid_next;
      pend      <= pend_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    kind         <= kind_next;
    slot_out     <= slot_out_next;
    full_res     <= full_res_next;
    remaining_us <= remaining_us_next;
    last         <= last_next;
  end

endmodule

### rtl/timer_bank_unit.sv
// channel | handshake            | fields
// --------+----------------------+----------------------------------------------
// input   | in_valid, in_stall   | mode, slot, interval_us, delta_us
// result  | out_valid, out_stall | kind, slot_out, full_res, remaining_us, last
//
// an item walks the row of slot cells, one cell a cycle unless a result stall or pending
// fires hold the chain, and passes from the chain end into the result register.
// a new item is taken only once the chain is empty, so items never overlap in it.
// a tick sends its fires one at a time after the chain, pausing on a stall, lowest slot first.
// synchronous reset frees every slot; there is no clearing pass.
// result stall holds the result register, then the item at the chain end.
module timer_bank_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tbu_pkg::MODE_W-1:0] mode,
  input  logic [tbu_pkg::SLOT_W-1:0] slot,
  input  logic [tbu_pkg::TIME_W-1:0] interval_us,
  input  logic [tbu_pkg::DELTA_W-1:0] delta_us,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tbu_pkg::KIND_W-1:0] kind,
  output logic [tbu_pkg::SLOT_W-1:0] slot_out,
  output logic                       full_res,
  output logic [tbu_pkg::TIME_W-1:0] remaining_us,
  output logic                       last
);
  import tbu_pkg::*;

  link_t chain [TIMER_SLOTS+1];
  link_t entry;
  logic  accept;
  logic  adv;
  logic  take;
  logic  busy;

  // chain occupancy, the block takes items only when it is empty
  always_comb begin
    busy = 1'b0;
    for (int k = 0; k <= TIMER_SLOTS; k++) begin
      busy = busy | chain[k].vld;
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign adv      = !chain[TIMER_SLOTS].vld || take;

  // fresh item entering the first cell
  always_comb begin
    entry           = '0;
    entry.vld       = 1'b1;
    entry.mode      = mode_t'(mode);
    entry.slot      = slot;
    entry.ival      = interval_us;
    entry.delta     = delta_us;
    entry.placed    = 1'b0;
    entry.place_idx = '0;
    entry.fires     = '0;
    entry.rem       = '0;
  end

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else if (accept) begin
      chain[0] <= entry;
    end else if (adv) begin
      chain[0].vld <= 1'b0;
    end
  end

  // row of slot cells
  for (genvar k = 0; k < TIMER_SLOTS; k++) begin : g_cell
    tbu_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(k)),
      .adv     (adv),
      .lnk_in  (chain[k]),
      .lnk_out (chain[k+1])
    );
  end

  // result sequencing
  tbu_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .lnk          (chain[TIMER_SLOTS]),
    .take         (take),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .kind         (kind),
    .slot_out     (slot_out),
    .full_res     (full_res),
    .remaining_us (remaining_us),
    .last         (last)
  );

endmodule

### rtl/tbu_checker.sv
`include "timer_bank_unit_assert.svh"

module tbu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [tbu_pkg::KIND_W-1:0] kind,
  input logic [tbu_pkg::SLOT_W-1:0] slot_out,
  input logic                       full_res,
  input logic [tbu_pkg::TIME_W-1:0] remaining_us,
  input logic                       last
);
  import tbu_pkg::*;

  // whole result payload in one vector
  logic [KIND_W+SLOT_W+TIME_W+1:0] res_bits;

  assign res_bits = {kind, slot_out, full_res, remaining_us, last};

  // a stalled result stays
  `TBU_ASSERT_NXT(a_valid_hold, out_valid && out_stall, out_valid)

  // a stalled result keeps its payload
  `TBU_ASSERT_NXT(a_payload_hold, out_valid && out_stall, $stable(res_bits))

  // add and query answers close their item
  `TBU_ASSERT_IMP(a_single_last, out_valid && (kind != KIND_FIRE), last)

  // a full answer is an add answer on slot zero
  `TBU_ASSERT_IMP(a_full_add, out_valid && full_res, (kind == KIND_ADD) && (slot_out == '0))

  // remaining time only on query answers
  `TBU_ASSERT_IMP(a_rem_query, out_valid && (kind != KIND_QUERY), remaining_us == '0)

endmodule

bind timer_bank_unit tbu_checker u_tbu_checker (.*);
